/* hdl/itoa_pkg.sv */
// shared types, constants and helpers for the integer to ascii formatter
package itoa_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_MINUS   = 8'h2d;

	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic hex;
		logic neg;
		logic conv_last;
		logic top_zero;
		logic cnt_last;
		logic slot_free;
	} status_t;

	function automatic int dec_digits(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

	function automatic int hex_digits(input int bits);
		return (bits + 3) / 4;
	endfunction

	function automatic int num_digits(input int bits);
		return (dec_digits(bits) > hex_digits(bits)) ? dec_digits(bits) : hex_digits(bits);
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'b0000, d};
		end else begin
			c = CHAR_LOWER_A + {4'b0000, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

/* hdl/integer_to_ascii_formatter_top.sv */
// top level of the integer to ascii formatter
// input channel: in_valid / in_stall with value and mode (0 signed decimal,
//   1 unsigned lowercase hex); one word is the number to print
// output channel: out_valid / out_stall with char_code and last; one word
//   per character, most significant first, last set on the final one
// a leading minus comes first for negative decimal input, zero prints as 0
// decimal: the accept state, VALUE_BITS shift-add-3 steps build the bcd
//   digits, then the sign state (the minus goes out here), then each of
//   the bcd digit slots is either skipped or sent, with a pass from the
//   skip state to the emit state in between
// hex: the accept state, a convert state and the sign state, then the
//   same digit slot walk
// the first character is registered and appears in the cycle after it is
//   formed; a new word is taken only once the previous number has handed
//   over its last character to the output register
// a stalled receiver holds the output register and the sequencer waits
// reset clears the sequencer and the output valid flag
module integer_to_ascii_formatter_top #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  mode,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            char_code,
	output logic                  last
);
	import itoa_pkg::*;

	cmd_t    cmd;
	status_t st;

	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	itoa_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.mode      (mode),
		.cmd       (cmd),
		.st        (st),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.char_code (char_code),
		.last      (last)
	);

endmodule

/* hdl/itoa_ctrl.sv */
// controller state machine: sequences load, conversion, sign and digit output
module itoa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  itoa_pkg::status_t st,
	output itoa_pkg::cmd_t    cmd
);
	import itoa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				if (st.hex) begin
					state_d = ST_SIGN;
				end else begin
					cmd.step = 1'b1;
					if (st.conv_last) begin
						state_d = ST_SIGN;
					end
				end
			end
			ST_SIGN: begin
				if (!st.neg) begin
					state_d = ST_SKIP;
				end else if (st.slot_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (st.top_zero && !st.cnt_last) begin
					cmd.skip = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.slot_free) begin
					cmd.emit_digit = 1'b1;
					if (st.cnt_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/itoa_dp.sv */
// datapath: magnitude, shift-add-3 binary to bcd, digit register and output word register
module itoa_dp #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  mode,
	input  itoa_pkg::cmd_t        cmd,
	output itoa_pkg::status_t     st,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [7:0]            char_code,
	output logic                  last
);
	import itoa_pkg::*;

	localparam int NDIG = num_digits(VALUE_BITS);
	localparam int DW   = NDIG * 4;
	localparam int CW   = $clog2(NDIG + 1);
	localparam int BW   = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] bin_q;
	logic [DW-1:0]         dig_q;
	logic [DW-1:0]         dig_adj;
	logic [CW-1:0]         cnt_q;
	logic [BW-1:0]         bitcnt_q;
	logic                  neg_q;
	logic                  hex_q;
	logic [7:0]            char_code_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg_in;
	logic                  slot_free;

	assign neg_in    = (mode == MODE_DEC) && value[VALUE_BITS-1];
	assign mag       = neg_in ? (~value + VALUE_BITS'(1)) : value;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			dig_adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? (dig_q[i*4 +: 4] + 4'd3)
			                                              : dig_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q    <= neg_in;
			hex_q    <= (mode == MODE_HEX);
			bin_q    <= mag;
			bitcnt_q <= BW'(VALUE_BITS);
			cnt_q    <= CW'(NDIG);
			dig_q    <= (mode == MODE_HEX) ? DW'(value) : '0;
		end else if (cmd.step) begin
			dig_q    <= {dig_adj[DW-2:0], bin_q[VALUE_BITS-1]};
			bin_q    <= bin_q << 1;
			bitcnt_q <= bitcnt_q - BW'(1);
		end else if (cmd.skip || cmd.emit_digit) begin
			dig_q <= dig_q << 4;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_code_q <= CHAR_MINUS;
			last_q      <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_code_q <= digit_char(dig_q[DW-1 -: 4]);
			last_q      <= (cnt_q == CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		st.hex       = hex_q;
		st.neg       = neg_q;
		st.conv_last = (bitcnt_q == BW'(1));
		st.top_zero  = (dig_q[DW-1 -: 4] == 4'd0);
		st.cnt_last  = (cnt_q == CW'(1));
		st.slot_free = slot_free;
	end

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign last      = last_q;

endmodule

/* hdl/itoa_chk.sv */
// port level checker for the integer to ascii formatter, bound to the top level
module itoa_chk #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [VALUE_BITS-1:0] value,
	input logic                  mode,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [7:0]            char_code,
	input logic                  last
);
	import itoa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last))
		else $error("output word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == CHAR_MINUS)
			|| ((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 8'd9))
			|| ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_A + 8'd5)))
		else $error("character out of the digit and sign set");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == CHAR_MINUS) |-> !last)
		else $error("minus sign flagged as final character");

endmodule

bind integer_to_ascii_formatter_top itoa_chk #(.VALUE_BITS(VALUE_BITS)) u_itoa_chk (.*);
